FILE: hdl/sdil_pkg.sv
// Shared types and constants for the sorted descending insert list.
package sdil_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int SCORE_W = 16;
  localparam int TAG_W   = 16;
  localparam int CMD_W   = 2;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [TAG_W-1:0]          tag_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    score_t score;
    tag_t   tag;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    score_t           score;
    tag_t             tag;
    logic [IDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    score_t           entry_score;
    tag_t             entry_tag;
    logic [CNT_W-1:0] count;
    stat_e            status;
  } rsp_t;

endpackage

FILE: hdl/sorted_descending_insert_list_core.sv
// Top level of the sorted descending insert list: handshakes and result register.
//
// Holds up to 128 entries (signed Q8.8 score plus 16-bit tag) in descending
// score order in a single-port-write, registered-read table memory. One
// transaction in gives exactly one transaction out. An insert walks up from
// the bottom of the table through one shared signed comparator, one slot per
// cycle, moving each lower-or-equal-scored entry down as it goes; a new entry
// lands ahead of stored entries of equal score. In-range reads pass through
// the read state to capture the registered memory data; clears, refused
// inserts and out-of-range reads go straight to the done state. in_stall_o
// is high while a transaction is in work; the result register lets the next
// transaction be accepted while the last result still waits downstream.
// An insert into a full table is refused with status full; a read at or
// beyond the count returns status range with zero score and tag. No clearing
// pass is needed after reset: only slots below the count are ever read.
module sorted_descending_insert_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sdil_pkg::CMD_W-1:0]    command_i,
  input  logic signed [sdil_pkg::SCORE_W-1:0] score_i,
  input  logic [sdil_pkg::TAG_W-1:0]    tag_i,
  input  logic [sdil_pkg::IDX_W-1:0]    read_index_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sdil_pkg::POS_W-1:0]    position_o,
  output logic signed [sdil_pkg::SCORE_W-1:0] entry_score_o,
  output logic [sdil_pkg::TAG_W-1:0]    entry_tag_o,
  output logic [sdil_pkg::CNT_W-1:0]    count_o,
  output logic [sdil_pkg::STAT_W-1:0]   status_o
);

  logic           eng_idle;
  logic           eng_start;
  logic           rsp_valid;
  logic           rsp_load;
  sdil_pkg::req_t req;
  sdil_pkg::rsp_t rsp;

  logic           out_valid_q;
  sdil_pkg::rsp_t out_q;

  // Accept only when the sequencer is idle; one transaction in work at a time.
  assign in_stall_o = !eng_idle;
  assign eng_start  = in_valid_i && !in_stall_o;

  assign req = '{command:    command_i,
                 score:      score_i,
                 tag:        tag_i,
                 read_index: read_index_i};

  sdil_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (eng_start),
    .req_i       (req),
    .idle_o      (eng_idle),
    .rsp_valid_o (rsp_valid),
    .rsp_taken_i (rsp_load),
    .rsp_o       (rsp)
  );

  // Result register: loads when empty or when its current transaction leaves.
  assign rsp_load = rsp_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = out_q.position;
  assign entry_score_o = out_q.entry_score;
  assign entry_tag_o   = out_q.entry_tag;
  assign count_o       = out_q.count;
  assign status_o      = out_q.status;

  // The sequencer never offers a result while it is ready for new work.
  a_idle_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(eng_idle && rsp_valid))
    else $error("sequencer idle with a pending result");

  // The table never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= sdil_pkg::CNT_W'(sdil_pkg::DEPTH)))
    else $error("count beyond table depth");

  // A refused insert only happens on a full table.
  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == sdil_pkg::STAT_FULL))
      |-> (count_o == sdil_pkg::CNT_W'(sdil_pkg::DEPTH)))
    else $error("insert refused on a table that is not full");

  // A range error only reports an index at or beyond the count.
  a_range_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == sdil_pkg::STAT_RANGE))
      |-> (position_o >= count_o))
    else $error("range error on an index below the count");

endmodule

FILE: hdl/sdil_engine.sv
// Table memory, count and the walk sequencer that inserts, reads and clears.
module sdil_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sdil_pkg::req_t    req_i,
  output logic              idle_o,
  output logic              rsp_valid_o,
  input  logic              rsp_taken_i,
  output sdil_pkg::rsp_t    rsp_o
);

  sdil_pkg::state_e state_q, state_d;
  logic [sdil_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [sdil_pkg::CNT_W-1:0] hole_q, hole_d;
  sdil_pkg::req_t   req_q;
  sdil_pkg::entry_t rd_q;

  // result payload
  logic [sdil_pkg::POS_W-1:0] pos_q, pos_d;
  sdil_pkg::score_t           rscore_q, rscore_d;
  sdil_pkg::tag_t             rtag_q, rtag_d;
  sdil_pkg::stat_e            stat_q, stat_d;
  logic                       res_load;

  // memory port
  sdil_pkg::entry_t mem_q [sdil_pkg::DEPTH];
  logic                       mem_we, mem_re;
  logic [sdil_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
  sdil_pkg::entry_t           mem_wdata;

  logic new_lt;  // new score strictly below the stored one
  logic full;
  logic rd_ok;
  sdil_pkg::entry_t new_entry;

  assign new_lt    = req_q.score < rd_q.score;
  assign full      = cnt_q >= sdil_pkg::CNT_W'(sdil_pkg::DEPTH);
  assign rd_ok     = sdil_pkg::CNT_W'(req_i.read_index) < cnt_q;
  assign new_entry = '{score: req_q.score, tag: req_q.tag};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdil_pkg::ST_IDLE: begin
        if (start_i) begin
          case (req_i.command)
            sdil_pkg::CMD_INSERT: begin
              if (full) begin
                state_d = sdil_pkg::ST_DONE;
              end else if (cnt_q == '0) begin
                state_d = sdil_pkg::ST_PLACE;
              end else begin
                state_d = sdil_pkg::ST_SCAN;
              end
            end
            sdil_pkg::CMD_READ: begin
              state_d = rd_ok ? sdil_pkg::ST_READ : sdil_pkg::ST_DONE;
            end
            default: state_d = sdil_pkg::ST_DONE;
          endcase
        end
      end
      sdil_pkg::ST_SCAN: begin
        if (new_lt) begin
          state_d = sdil_pkg::ST_DONE;
        end else if (hole_q == sdil_pkg::CNT_W'(1)) begin
          state_d = sdil_pkg::ST_PLACE;
        end
      end
      sdil_pkg::ST_PLACE: state_d = sdil_pkg::ST_DONE;
      sdil_pkg::ST_READ:  state_d = sdil_pkg::ST_DONE;
      sdil_pkg::ST_DONE: begin
        if (rsp_taken_i) begin
          state_d = sdil_pkg::ST_IDLE;
        end
      end
      default: state_d = sdil_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    cnt_d     = cnt_q;
    hole_d    = hole_q;
    mem_we    = 1'b0;
    mem_waddr = hole_q[sdil_pkg::IDX_W-1:0];
    mem_wdata = new_entry;
    mem_re    = 1'b0;
    mem_raddr = req_i.read_index;
    res_load  = 1'b0;
    pos_d     = '0;
    rscore_d  = '0;
    rtag_d    = '0;
    stat_d    = sdil_pkg::STAT_OK;
    case (state_q)
      sdil_pkg::ST_IDLE: begin
        if (start_i) begin
          res_load = 1'b1;
          case (req_i.command)
            sdil_pkg::CMD_INSERT: begin
              hole_d = cnt_q;
              if (full) begin
                stat_d = sdil_pkg::STAT_FULL;
              end else if (cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = sdil_pkg::IDX_W'(cnt_q - sdil_pkg::CNT_W'(1));
              end
            end
            sdil_pkg::CMD_READ: begin
              pos_d = sdil_pkg::POS_W'(req_i.read_index);
              if (rd_ok) begin
                mem_re = 1'b1;
              end else begin
                stat_d = sdil_pkg::STAT_RANGE;
              end
            end
            sdil_pkg::CMD_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      sdil_pkg::ST_SCAN: begin
        mem_we = 1'b1;
        if (new_lt) begin
          cnt_d    = cnt_q + sdil_pkg::CNT_W'(1);
          res_load = 1'b1;
          pos_d    = sdil_pkg::POS_W'(hole_q);
          rscore_d = req_q.score;
          rtag_d   = req_q.tag;
        end else begin
          // move the stored entry down one slot, fetch the next one up
          mem_wdata = rd_q;
          hole_d    = hole_q - sdil_pkg::CNT_W'(1);
          if (hole_q != sdil_pkg::CNT_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = sdil_pkg::IDX_W'(hole_q - sdil_pkg::CNT_W'(2));
          end
        end
      end
      sdil_pkg::ST_PLACE: begin
        mem_we   = 1'b1;
        cnt_d    = cnt_q + sdil_pkg::CNT_W'(1);
        res_load = 1'b1;
        pos_d    = sdil_pkg::POS_W'(hole_q);
        rscore_d = req_q.score;
        rtag_d   = req_q.tag;
      end
      sdil_pkg::ST_READ: begin
        res_load = 1'b1;
        pos_d    = sdil_pkg::POS_W'(req_q.read_index);
        rscore_d = rd_q.score;
        rtag_d   = rd_q.tag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdil_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    if (start_i) begin
      req_q <= req_i;
    end
    if (res_load) begin
      pos_q    <= pos_d;
      rscore_q <= rscore_d;
      rtag_q   <= rtag_d;
      stat_q   <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign idle_o      = state_q == sdil_pkg::ST_IDLE;
  assign rsp_valid_o = state_q == sdil_pkg::ST_DONE;
  assign rsp_o = '{position:    pos_q,
                   entry_score: rscore_q,
                   entry_tag:   rtag_q,
                   count:       cnt_q,
                   status:      stat_q};

endmodule

FILE: dv/sdil_order_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted descending insert list: keeps its own table and compares each result.
module sdil_order_checker
  import sdil_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CMD_W-1:0]       command_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic [TAG_W-1:0]       tag_i,
  input  logic [IDX_W-1:0]       read_index_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [POS_W-1:0]       position_i,
  input  logic signed [SCORE_W-1:0] entry_score_i,
  input  logic [TAG_W-1:0]       entry_tag_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [STAT_W-1:0]      status_i,
  output int unsigned            mismatches_o,
  output int unsigned            awaited_o
);

  score_t      kept_score [DEPTH];
  tag_t        kept_tag   [DEPTH];
  int unsigned kept_count;
  rsp_t        awaited_results [$];
  int unsigned mismatch_total = 0;
  int unsigned awaited_depth  = 0;

  assign mismatches_o = mismatch_total;
  assign awaited_o    = awaited_depth;

  task automatic report_mismatch(string what);
    mismatch_total++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(string name, longint unsigned got, longint unsigned want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic rsp_t apply_command(logic [CMD_W-1:0] cmd, score_t sc, tag_t tg,
                                         logic [IDX_W-1:0] idx);
    rsp_t        res;
    int unsigned slot;
    int unsigned i;
    res        = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_INSERT: begin
        if (kept_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          slot = 0;
          // the walk stops at an equal score, so ties land ahead of older entries
          while (slot < kept_count && sc < kept_score[slot]) slot++;
          for (i = kept_count; i > slot; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_tag[i]   = kept_tag[i-1];
          end
          kept_score[slot] = sc;
          kept_tag[slot]   = tg;
          kept_count++;
          res.position    = POS_W'(slot);
          res.entry_score = sc;
          res.entry_tag   = tg;
        end
      end
      CMD_READ: begin
        res.position = POS_W'(idx);
        if (idx >= kept_count) begin
          res.status = STAT_RANGE;
        end else begin
          res.entry_score = kept_score[idx];
          res.entry_tag   = kept_tag[idx];
        end
      end
      CMD_CLEAR: kept_count = 0;
      default: ;
    endcase
    res.count = CNT_W'(kept_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      kept_count = 0;
      awaited_results.delete();
      awaited_depth = 0;
    end else begin
      // results first: nothing accepted at this edge can already be answered
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited, position 0x%0h status %0d",
                                    position_i, status_i));
        end else begin
          want = awaited_results.pop_front();
          compare_field("position", position_i, want.position);
          compare_field("entry_score", entry_score_i, want.entry_score);
          compare_field("entry_tag", entry_tag_i, want.entry_tag);
          compare_field("count", count_i, want.count);
          compare_field("status", status_i, want.status);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_command(command_i, score_i, tag_i, read_index_i));
      end
      awaited_depth = awaited_results.size();
    end
  end

endmodule

FILE: dv/tb_sorted_descending_insert_list_core.sv
`timescale 1ns / 100ps
// Testbench top for the sorted descending insert list: stimulus, idling, watchdog and verdict.
module tb_sorted_descending_insert_list_core;
  import sdil_pkg::*;

  // Command code 3 is not decoded by the block; it must still answer.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam score_t SCORE_MAX = 16'sh7FFF;
  localparam score_t SCORE_MIN = 16'sh8000;

  // Run shape: directed part, then random transactions up to this total.
  localparam int ITEM_TARGET = 730;
  // Window of transactions with no idling on either channel.
  localparam int CALM_FROM   = 350;
  localparam int CALM_TO     = 480;
  // Quiet tail after the last result, to catch any stray one.
  localparam int SETTLE_CYCLES  = 150;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          command_i     = CMD_CLEAR;
  logic signed [SCORE_W-1:0] score_i       = '0;
  logic [TAG_W-1:0]          tag_i         = '0;
  logic [IDX_W-1:0]          read_index_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic [POS_W-1:0]          position_o;
  logic signed [SCORE_W-1:0] entry_score_o;
  logic [TAG_W-1:0]          entry_tag_o;
  logic [CNT_W-1:0]          count_o;
  logic [STAT_W-1:0]         status_o;

  int unsigned mismatches;
  int unsigned awaited;

  // Stimulus-side bookkeeping: only used to aim read indexes and to know when
  // the table is full; the checker owns the real prediction.
  int          table_fill = 0;
  int unsigned sent       = 0;
  bit          calm       = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  sorted_descending_insert_list_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .score_i       (score_i),
    .tag_i         (tag_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_o    (position_o),
    .entry_score_o (entry_score_o),
    .entry_tag_o   (entry_tag_o),
    .count_o       (count_o),
    .status_o      (status_o)
  );

  sdil_order_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .score_i       (score_i),
    .tag_i         (tag_i),
    .read_index_i  (read_index_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_i    (position_o),
    .entry_score_i (entry_score_o),
    .entry_tag_i   (entry_tag_o),
    .count_i       (count_o),
    .status_i      (status_o),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited)
  );

  // Result side back-pressure: random stalls about 21% of cycles, none in the calm window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 21);
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, awaited);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Scores: extremes and a handful of whole values (to force ties) mixed
  // with fully random Q8.8 values.
  function automatic score_t pick_score();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return SCORE_MAX;
    if (roll < 20) return SCORE_MIN;
    if (roll < 45) return score_t'((int'($urandom_range(0, 8)) - 4) * 256);
    return score_t'($urandom);
  endfunction

  // Read indexes: mostly inside the table, some around the count, some anywhere.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 99);
    if (roll < 60 && table_fill > 0) return IDX_W'($urandom_range(0, table_fill - 1));
    if (roll < 80) begin
      near = table_fill + int'($urandom_range(0, 2)) - 1;
      if (near < 0) near = 0;
      if (near > DEPTH - 1) near = DEPTH - 1;
      return IDX_W'(near);
    end
    return IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // Presents one transaction, with optional random idle cycles ahead of it,
  // and returns at the edge where it is taken. Valid stays high on return so
  // back-to-back transactions need no idle gap. Stall is sampled at the
  // falling edge, where it has settled for the coming rising edge.
  task automatic post_command(logic [CMD_W-1:0] cmd, score_t sc, tag_t tg,
                              logic [IDX_W-1:0] idx);
    bit taken;
    calm = (sent >= CALM_FROM) && (sent < CALM_TO);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    score_i      <= sc;
    tag_i        <= tg;
    read_index_i <= idx;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sent++;
    if (cmd == CMD_INSERT && table_fill < DEPTH) table_fill++;
    if (cmd == CMD_CLEAR) table_fill = 0;
  endtask

  // Holds the input side off until every awaited result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned      roll;
    int unsigned      phase_len;
    logic [CMD_W-1:0] cmd;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // reads on an empty table are out of range, including the top index
    post_command(CMD_READ, '0, '0, '0);
    post_command(CMD_READ, '0, '0, IDX_W'(DEPTH - 1));
    // undecoded command with every field bit set: ignored, count unchanged
    post_command(CMD_UNUSED, score_t'(16'hFFFF), tag_t'(16'hFFFF), '1);
    // build a small table: extremes, a tie on zero, a tie on the maximum
    post_command(CMD_INSERT, '0, tag_t'(16'h0000), '0);
    post_command(CMD_INSERT, SCORE_MAX, tag_t'(16'hFFFF), '0);
    post_command(CMD_INSERT, SCORE_MIN, tag_t'(16'h1234), '0);
    post_command(CMD_INSERT, '0, tag_t'(16'hAAAA), '0);
    post_command(CMD_INSERT, score_t'(16'h0100), tag_t'(16'h5555), '0);
    post_command(CMD_INSERT, score_t'(16'hFFFF), tag_t'(16'h0F0F), '0);
    post_command(CMD_INSERT, SCORE_MAX, tag_t'(16'h0001), '0);
    // read back every slot, then the first slot past the count and the top index
    for (int k = 0; k < 8; k++) post_command(CMD_READ, '0, '0, IDX_W'(k));
    post_command(CMD_READ, '0, '0, IDX_W'(DEPTH - 1));
    post_command(CMD_CLEAR, '0, '0, '0);
    post_command(CMD_READ, '0, '0, '0);
    // tie at the minimum on a fresh table
    post_command(CMD_INSERT, SCORE_MIN, tag_t'(16'hFFFF), '0);
    post_command(CMD_INSERT, SCORE_MIN, tag_t'(16'h0000), '0);
    post_command(CMD_UNUSED, '0, '0, '0);
    post_command(CMD_CLEAR, score_t'(16'hFFFF), tag_t'(16'hFFFF), '1);

    // --- fill to capacity, then push past it ---
    while (table_fill < DEPTH) begin
      if ($urandom_range(0, 99) < 85) begin
        post_command(CMD_INSERT, pick_score(), tag_t'($urandom), pick_index());
      end else begin
        post_command(CMD_READ, pick_score(), tag_t'($urandom), pick_index());
      end
    end
    repeat (3) post_command(CMD_INSERT, pick_score(), tag_t'($urandom), pick_index());
    post_command(CMD_READ, '0, '0, IDX_W'(DEPTH - 1));
    post_command(CMD_READ, '0, '0, '0);
    repeat (10) post_command(CMD_READ, pick_score(), tag_t'($urandom), pick_index());
    // let the block empty out completely before moving on
    drain_results();

    // --- random phases: mostly inserts and reads, occasional clears and noise ---
    while (sent < ITEM_TARGET) begin
      phase_len = $urandom_range(15, 60);
      if ($urandom_range(0, 1) == 0) begin
        post_command(CMD_CLEAR, pick_score(), tag_t'($urandom), pick_index());
      end
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          cmd = CMD_INSERT;
        end else if (roll < 92) begin
          cmd = CMD_READ;
        end else if (roll < 96) begin
          cmd = CMD_CLEAR;
        end else begin
          cmd = CMD_UNUSED;
        end
        post_command(cmd, pick_score(), tag_t'($urandom), pick_index());
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    // --- wind down: everything answered, then a quiet tail for stray results ---
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sdil_pkg.sv
hdl/sdil_engine.sv
hdl/sorted_descending_insert_list_core.sv
dv/sdil_order_checker.sv
dv/tb_sorted_descending_insert_list_core.sv
